### sv/pipr_pkg.sv
// ============================================================================
// pipr_pkg: shared types and helpers for the ray-cast point-in-polygon core
// Holds the transaction payload structs, the register index codes, the
// arithmetic widths and the ratio test used on the cross and dot products.
// ============================================================================
package pipr_pkg;

    // Coordinate width (signed Q9.23 degrees).
    localparam int COORD_W = 32;
    // A difference of two coordinates.
    localparam int DIFF_W  = COORD_W + 1;
    // A product of two differences.
    localparam int PROD_W  = 2 * DIFF_W;
    // Sums of products, including the projected far end of an edge.
    localparam int SUM_W   = PROD_W + 2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_LON   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_LAT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RAY_END_LON = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RAY_END_LAT = 2'd3;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [SUM_W-1:0]   sum_t;

    // One polygon vertex.
    typedef struct packed {
        logic signed [COORD_W-1:0] vertex_lon;
        logic signed [COORD_W-1:0] vertex_lat;
        logic                      ring_start;
        logic                      query_start;
    } vertex_t;

    // One result per vertex.
    typedef struct packed {
        logic edge_crossed;
        logic inside_res;
    } result_t;

    // Exact difference of two coordinates.
    function automatic diff_t coord_diff(input coord_t a, input coord_t b);
        return DIFF_W'(a) - DIFF_W'(b);
    endfunction

    // Exact signed product of two differences.
    function automatic prod_t diff_mul(input diff_t a, input diff_t b);
        return PROD_W'(a) * PROD_W'(b);
    endfunction

    // True when x/d lies in [0,1], ends included, for a nonzero d.
    function automatic logic ratio_in_unit(input sum_t x, input sum_t d);
        logic d_pos;
        d_pos = (d > 0);
        if (d_pos)
            return (x >= 0) && (x <= d);
        else
            return (x <= 0) && (x >= d);
    endfunction

endpackage

### sv/point_in_polygon_ray_cast_core.sv
// ============================================================================
// point_in_polygon_ray_cast_core: streaming ray-cast point-in-polygon tester
// Tests each polygon edge against the segment from the configured point to
// the configured ray end and keeps the running crossing parity.
// ============================================================================
// Vertices stream in one transaction per clock and each produces exactly one
// result transaction. The edge test runs in a six-stage pipeline: input
// register, coordinate differences, twelve parallel 33x33 products, sums of
// product pairs, sign and magnitude compares, and the result register. The
// sustained rate is one vertex per cycle as long as results are taken.
// Each stage advances independently, so bubbles are squeezed out while the
// output is stalled. The point and ray end registers may only be written
// while no vertex is in flight. Arithmetic is exact: nothing is divided, the
// intersection parameters are compared against the cross-product
// denominator instead.
module point_in_polygon_ray_cast_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [pipr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pipr_pkg::COORD_W-1:0]        cfg_data,
    input  logic                                vertex_valid,
    output logic                                vertex_ready,
    input  pipr_pkg::vertex_t                   vertex,
    output logic                                result_valid,
    input  logic                                result_ready,
    output pipr_pkg::result_t                   result
);
    import pipr_pkg::*;

    // Configuration registers.
    coord_t point_lon_reg, point_lat_reg, ray_end_lon_reg, ray_end_lat_reg;

    // Previous vertex tracking and crossing parity.
    coord_t prev_lon_reg, prev_lat_reg;
    logic   have_prev_reg;
    logic   parity_reg;
    logic   parity_next;

    // Stage valids and load enables.
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic out_valid_reg;
    logic ld1, ld2, ld3, ld4, ld5, ld_out;

    // Stage 1: current vertex, previous vertex and control.
    coord_t s1_cx_reg, s1_cy_reg, s1_px_reg, s1_py_reg;
    logic   s1_edge_reg, s1_query_reg;

    // Stage 2: differences.
    diff_t s2_rx_reg, s2_ry_reg, s2_ex_reg, s2_ey_reg, s2_wx_reg, s2_wy_reg;
    logic  s2_edge_reg, s2_query_reg;

    // Stage 3: products.
    prod_t s3_rx_ey_reg, s3_ry_ex_reg, s3_wx_ey_reg, s3_wy_ex_reg;
    prod_t s3_wx_ry_reg, s3_wy_rx_reg, s3_rx_rx_reg, s3_ry_ry_reg;
    prod_t s3_wx_rx_reg, s3_wy_ry_reg, s3_ex_rx_reg, s3_ey_ry_reg;
    logic  s3_edge_reg, s3_query_reg;

    // Stage 4: cross and dot products.
    sum_t s4_den_reg, s4_tn_reg, s4_un_reg, s4_dd_reg, s4_a0_reg, s4_ea_reg;
    logic s4_edge_reg, s4_query_reg;

    // Stage 5: flags from the first compares, far end projection.
    sum_t s5_a1_reg, s5_dd_reg;
    logic s5_den_zero_reg, s5_un_zero_reg, s5_dd_zero_reg, s5_tu_ok_reg;
    logic s5_a0_in_reg, s5_a0_gt_reg, s5_a0_neg_reg;
    logic s5_edge_reg, s5_query_reg;

    // Result register.
    result_t result_reg;
    logic    hit;

    // Each stage loads when it is empty or its contents move on.
    assign ld_out       = !out_valid_reg || result_ready;
    assign ld5          = !s5_valid_reg || ld_out;
    assign ld4          = !s4_valid_reg || ld5;
    assign ld3          = !s3_valid_reg || ld4;
    assign ld2          = !s2_valid_reg || ld3;
    assign ld1          = !s1_valid_reg || ld2;
    assign vertex_ready = ld1;
    assign result_valid = out_valid_reg;
    assign result       = result_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_lon_reg   <= '0;
            point_lat_reg   <= '0;
            ray_end_lon_reg <= '0;
            ray_end_lat_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_POINT_LON:   point_lon_reg   <= cfg_data;
                REG_POINT_LAT:   point_lat_reg   <= cfg_data;
                REG_RAY_END_LON: ray_end_lon_reg <= cfg_data;
                REG_RAY_END_LAT: ray_end_lat_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Control state: stage valids, previous vertex flag and parity.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            have_prev_reg <= 1'b0;
            parity_reg    <= 1'b0;
        end
        else
        begin
            if (ld1)
                s1_valid_reg <= vertex_valid;
            if (ld2)
                s2_valid_reg <= s1_valid_reg;
            if (ld3)
                s3_valid_reg <= s2_valid_reg;
            if (ld4)
                s4_valid_reg <= s3_valid_reg;
            if (ld5)
                s5_valid_reg <= s4_valid_reg;
            if (ld_out)
                out_valid_reg <= s5_valid_reg;
            if (vertex_valid && ld1)
                have_prev_reg <= 1'b1;
            if (ld_out && s5_valid_reg)
                parity_reg <= parity_next;
        end
    end

    // Stage 1: capture the vertex and pair it with the previous one.
    always_ff @(posedge clk)
    begin
        if (vertex_valid && ld1)
        begin
            s1_cx_reg    <= vertex.vertex_lon;
            s1_cy_reg    <= vertex.vertex_lat;
            s1_px_reg    <= prev_lon_reg;
            s1_py_reg    <= prev_lat_reg;
            s1_edge_reg  <= have_prev_reg && !vertex.ring_start && !vertex.query_start;
            s1_query_reg <= vertex.query_start;
            prev_lon_reg <= vertex.vertex_lon;
            prev_lat_reg <= vertex.vertex_lat;
        end
    end

    // Stage 2: ray, edge and point-to-vertex vectors.
    always_ff @(posedge clk)
    begin
        if (ld2)
        begin
            s2_rx_reg    <= coord_diff(ray_end_lon_reg, point_lon_reg);
            s2_ry_reg    <= coord_diff(ray_end_lat_reg, point_lat_reg);
            s2_ex_reg    <= coord_diff(s1_px_reg, s1_cx_reg);
            s2_ey_reg    <= coord_diff(s1_py_reg, s1_cy_reg);
            s2_wx_reg    <= coord_diff(s1_cx_reg, point_lon_reg);
            s2_wy_reg    <= coord_diff(s1_cy_reg, point_lat_reg);
            s2_edge_reg  <= s1_edge_reg;
            s2_query_reg <= s1_query_reg;
        end
    end

    // Stage 3: all products in parallel.
    always_ff @(posedge clk)
    begin
        if (ld3)
        begin
            s3_rx_ey_reg <= diff_mul(s2_rx_reg, s2_ey_reg);
            s3_ry_ex_reg <= diff_mul(s2_ry_reg, s2_ex_reg);
            s3_wx_ey_reg <= diff_mul(s2_wx_reg, s2_ey_reg);
            s3_wy_ex_reg <= diff_mul(s2_wy_reg, s2_ex_reg);
            s3_wx_ry_reg <= diff_mul(s2_wx_reg, s2_ry_reg);
            s3_wy_rx_reg <= diff_mul(s2_wy_reg, s2_rx_reg);
            s3_rx_rx_reg <= diff_mul(s2_rx_reg, s2_rx_reg);
            s3_ry_ry_reg <= diff_mul(s2_ry_reg, s2_ry_reg);
            s3_wx_rx_reg <= diff_mul(s2_wx_reg, s2_rx_reg);
            s3_wy_ry_reg <= diff_mul(s2_wy_reg, s2_ry_reg);
            s3_ex_rx_reg <= diff_mul(s2_ex_reg, s2_rx_reg);
            s3_ey_ry_reg <= diff_mul(s2_ey_reg, s2_ry_reg);
            s3_edge_reg  <= s2_edge_reg;
            s3_query_reg <= s2_query_reg;
        end
    end

    // Stage 4: denominator, parameter numerators and projections.
    always_ff @(posedge clk)
    begin
        if (ld4)
        begin
            s4_den_reg   <= SUM_W'(s3_rx_ey_reg) - SUM_W'(s3_ry_ex_reg);
            s4_tn_reg    <= SUM_W'(s3_wx_ey_reg) - SUM_W'(s3_wy_ex_reg);
            s4_un_reg    <= SUM_W'(s3_wx_ry_reg) - SUM_W'(s3_wy_rx_reg);
            s4_dd_reg    <= SUM_W'(s3_rx_rx_reg) + SUM_W'(s3_ry_ry_reg);
            s4_a0_reg    <= SUM_W'(s3_wx_rx_reg) + SUM_W'(s3_wy_ry_reg);
            s4_ea_reg    <= SUM_W'(s3_ex_rx_reg) + SUM_W'(s3_ey_ry_reg);
            s4_edge_reg  <= s3_edge_reg;
            s4_query_reg <= s3_query_reg;
        end
    end

    // Stage 5: proper crossing test and near end of the colinear test.
    always_ff @(posedge clk)
    begin
        if (ld5)
        begin
            s5_a1_reg       <= s4_a0_reg + s4_ea_reg;
            s5_dd_reg       <= s4_dd_reg;
            s5_den_zero_reg <= (s4_den_reg == '0);
            s5_un_zero_reg  <= (s4_un_reg == '0);
            s5_dd_zero_reg  <= (s4_dd_reg == '0);
            s5_tu_ok_reg    <= ratio_in_unit(s4_tn_reg, s4_den_reg)
                               && ratio_in_unit(s4_un_reg, s4_den_reg);
            s5_a0_in_reg    <= ratio_in_unit(s4_a0_reg, s4_dd_reg);
            s5_a0_gt_reg    <= (s4_a0_reg > s4_dd_reg);
            s5_a0_neg_reg   <= (s4_a0_reg < 0);
            s5_edge_reg     <= s4_edge_reg;
            s5_query_reg    <= s4_query_reg;
        end
    end

    // Final decision: colinear overlap or proper crossing, then parity.
    always_comb
    begin
        logic a1_in, a1_gt, a1_neg, colinear_hit;
        a1_in        = ratio_in_unit(s5_a1_reg, s5_dd_reg);
        a1_gt        = (s5_a1_reg > s5_dd_reg);
        a1_neg       = (s5_a1_reg < 0);
        colinear_hit = s5_un_zero_reg && !s5_dd_zero_reg
                       && (s5_a0_in_reg || a1_in
                           || (s5_a0_gt_reg && a1_neg)
                           || (a1_gt && s5_a0_neg_reg));
        hit          = s5_edge_reg
                       && (s5_den_zero_reg ? colinear_hit : s5_tu_ok_reg);
        parity_next  = (parity_reg && !s5_query_reg) ^ hit;
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (ld_out && s5_valid_reg)
        begin
            result_reg.edge_crossed <= hit;
            result_reg.inside_res   <= parity_next;
        end
    end

endmodule
